// File: hdl/sediment_layer_pop_mixer_defines.svh
// assertion macros for the sediment layer pop mixer
`ifndef SEDIMENT_LAYER_POP_MIXER_DEFINES_SVH
`define SEDIMENT_LAYER_POP_MIXER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SLPM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// implication whose consequent is checked in the next cycle
`define SLPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// File: hdl/slpm_pkg.sv
// shared types and constants for the sediment layer pop mixer
`default_nettype none
package slpm_pkg;
   localparam int FracBitsDefault = 12;
   localparam int GPerKg = 1000;
   localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0]  layer_count;
      logic [31:0] surface_volume;
      logic [31:0] below_volume;
      logic [31:0] min_volume;
      logic [31:0] below_area;
      logic [31:0] surface_conc;
      logic [31:0] below_conc;
      logic        is_chemical;
      logic        last_species;
   } req_type;

   typedef struct packed {
      logic        popped;
      logic [31:0] new_below_conc;
      logic [31:0] buried_mass_kg;
      logic [31:0] merged_volume;
      logic [31:0] new_thickness;
      logic [7:0]  new_layer_count;
   } rsp_type;
endpackage
`default_nettype wire

// File: hdl/slpm_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating to 32 bits
`default_nettype none
module slpm_div #(
   parameter int NUM_W = 65,
   parameter int DEN_W = 33,
   parameter int TAG_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   input  wire logic [TAG_W-1:0] in_tag,
   output logic                  out_valid,
   output logic [31:0]           out_quot,
   output logic [TAG_W-1:0]      out_tag
);
   import slpm_pkg::*;
   localparam int RW = DEN_W + 1;

   logic             vld_ff  [NUM_W+1];
   logic [NUM_W-1:0] num_ff  [NUM_W+1];
   logic [DEN_W-1:0] den_ff  [NUM_W+1];
   logic [RW-1:0]    rem_ff  [NUM_W+1];
   logic [NUM_W-1:0] quo_ff  [NUM_W+1];
   logic [TAG_W-1:0] tag_ff  [NUM_W+1];
   logic             zero_ff [NUM_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      num_ff[0]  <= in_num;
      den_ff[0]  <= in_den;
      rem_ff[0]  <= '0;
      quo_ff[0]  <= '0;
      tag_ff[0]  <= in_tag;
      zero_ff[0] <= (in_den == '0);
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [RW-1:0] rem_in;
      logic          ge;
      always_comb begin
         rem_in = {rem_ff[s][RW-2:0], num_ff[s][NUM_W-1-s]};
         ge     = rem_in >= {1'b0, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_ff[s];
         end
         num_ff[s+1]  <= num_ff[s];
         den_ff[s+1]  <= den_ff[s];
         rem_ff[s+1]  <= ge ? rem_in - {1'b0, den_ff[s]} : rem_in;
         quo_ff[s+1]  <= {quo_ff[s][NUM_W-2:0], ge};
         tag_ff[s+1]  <= tag_ff[s];
         zero_ff[s+1] <= zero_ff[s];
      end
   end

   always_comb begin
      out_valid = vld_ff[NUM_W];
      out_tag   = tag_ff[NUM_W];
      if (zero_ff[NUM_W] || (quo_ff[NUM_W][NUM_W-1:32] != '0)) begin
         out_quot = AllOnes;
      end else begin
         out_quot = quo_ff[NUM_W][31:0];
      end
   end
endmodule
`default_nettype wire

// File: hdl/slpm_front.sv
// decode, products, buried mass and divider operands
`default_nettype none
module slpm_front #(
   parameter int FRAC_BITS = slpm_pkg::FracBitsDefault
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire slpm_pkg::req_type in_req,
   input  wire logic [2:0]      sim_mode,
   output logic                 out_valid,
   output logic [64:0]          conc_num,
   output logic [32:0]          conc_den,
   output logic [63:0]          thick_num,
   output logic [32:0]          thick_den,
   output slpm_pkg::rsp_type    out_side
);
   import slpm_pkg::*;

   // x / 1000 is (x / 8) / 125, taken by a rounded-up reciprocal, exact below 2^39
   localparam int MassShift = 46;
   localparam logic [39:0] MassRecip = 40'((64'd1 << MassShift) / (64'(GPerKg) >> 3) + 64'd1);

   // stage 1: decode and products
   logic          v1_ff;
   logic          pop1_ff, mix1_ff;
   logic [63:0]   ps1_ff, pb1_ff;
   logic [32:0]   vsum1_ff;
   req_type       r1_ff;

   logic pop_in, mix_in;
   always_comb begin
      pop_in = (in_req.surface_volume <= in_req.min_volume) && (in_req.layer_count > 8'd1);
      mix_in = pop_in && (!in_req.is_chemical || (sim_mode > 3'd2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      pop1_ff  <= pop_in;
      mix1_ff  <= mix_in;
      ps1_ff   <= in_req.surface_conc * in_req.surface_volume;
      pb1_ff   <= in_req.below_conc * in_req.below_volume;
      vsum1_ff <= {1'b0, in_req.surface_volume} + {1'b0, in_req.below_volume};
      r1_ff    <= in_req;
   end

   // stage 2: sums, merged volume and mass partial products
   logic          v2_ff;
   logic          pop2_ff, mix2_ff, msat2_ff;
   logic [64:0]   sum2_ff;
   logic [32:0]   vsum2_ff;
   logic [31:0]   merged2_ff;
   logic [39:0]   pp_hh2_ff, pp_hl2_ff, pp_lh2_ff, pp_ll2_ff;
   req_type       r2_ff;

   logic [64:0] sum_in;
   logic [31:0] merged_in;
   logic [63:0] grams_in;
   logic [38:0] eighth_in;
   always_comb begin
      sum_in    = {1'b0, ps1_ff} + {1'b0, pb1_ff};
      merged_in = !pop1_ff ? r1_ff.below_volume
                 : (vsum1_ff[32] ? AllOnes : vsum1_ff[31:0]);
      grams_in  = ps1_ff >> FRAC_BITS;
      eighth_in = grams_in[41:3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      pop2_ff    <= pop1_ff;
      mix2_ff    <= mix1_ff;
      // quotient needs more than 32 bits
      msat2_ff   <= grams_in >= (64'(GPerKg) << 32);
      sum2_ff    <= sum_in;
      vsum2_ff   <= vsum1_ff;
      merged2_ff <= merged_in;
      pp_hh2_ff  <= eighth_in[38:20] * MassRecip[39:20];
      pp_hl2_ff  <= eighth_in[38:20] * MassRecip[19:0];
      pp_lh2_ff  <= eighth_in[19:0] * MassRecip[39:20];
      pp_ll2_ff  <= eighth_in[19:0] * MassRecip[19:0];
      r2_ff      <= r1_ff;
   end

   // stage 3: mass quotient and operands
   logic [79:0] mass_prod;
   logic [31:0] mass_in;
   always_comb begin
      mass_prod = (80'(pp_hh2_ff) << 40) + (80'(pp_hl2_ff) << 20)
                + (80'(pp_lh2_ff) << 20) + 80'(pp_ll2_ff);
      mass_in   = msat2_ff ? AllOnes : mass_prod[MassShift+31:MassShift];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= v2_ff;
      end
      conc_num  <= sum2_ff;
      conc_den  <= vsum2_ff;
      thick_num <= 64'(merged2_ff) << FRAC_BITS;
      thick_den <= {1'b0, r2_ff.below_area};
      out_side.popped          <= pop2_ff;
      out_side.new_below_conc  <= mix2_ff ? '0 : r2_ff.below_conc;
      out_side.buried_mass_kg  <= mix2_ff ? mass_in : '0;
      out_side.merged_volume   <= merged2_ff;
      // thickness slot carries the mixed flag until the divider fills it
      out_side.new_thickness   <= {31'd0, mix2_ff};
      out_side.new_layer_count <= pop2_ff ? r2_ff.layer_count - 8'd1 : r2_ff.layer_count;
   end
endmodule
`default_nettype wire

// File: hdl/sediment_layer_pop_mixer.sv
// top level of the sediment layer pop mixer
//
//   channel | ports            | transfer
//   req     | start, req_data  | start high and busy low at a clock edge
//   rsp     | rsp_valid, rsp_* | rsp_valid high for one cycle, always taken
//   csr     | csr_we, csr_wdata| csr_we high at a clock edge
//
// one item per cycle: three front stages, then the 65-stage bit-per-stage
// dividers for concentration and thickness side by side.
// buried mass is a reciprocal multiply inside the front stages.
// busy stays low: the receiver cannot stall, so nothing backs up.
// reset clears all valid bits and sets sim_mode to 1.
`default_nettype none
module sediment_layer_pop_mixer #(
   parameter int FRAC_BITS = slpm_pkg::FracBitsDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire slpm_pkg::req_type req_data,
   output logic                   rsp_valid,
   output slpm_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_wdata
);
   import slpm_pkg::*;
   `include "sediment_layer_pop_mixer_defines.svh"

   localparam int SIDE_W = $bits(rsp_type);

   logic [2:0]  sim_mode_ff;
   logic        fv;
   logic [64:0] conc_num;
   logic [32:0] conc_den;
   logic [63:0] thick_num;
   logic [32:0] thick_den;
   rsp_type     side;
   logic        cv, tv;
   logic [31:0] cq, tq;
   logic [SIDE_W-1:0] ctag;
   logic [0:0]  ttag;

   always_ff @(posedge clock) begin
      if (reset) begin
         sim_mode_ff <= 3'd1;
      end else if (csr_we) begin
         sim_mode_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   slpm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .in_valid(start & ~busy), .in_req(req_data),
      .sim_mode(sim_mode_ff), .out_valid(fv), .conc_num, .conc_den,
      .thick_num, .thick_den, .out_side(side)
   );

   slpm_div #(.NUM_W(65), .DEN_W(33), .TAG_W(SIDE_W)) u_conc (
      .clock, .reset, .in_valid(fv), .in_num(conc_num), .in_den(conc_den),
      .in_tag(side), .out_valid(cv), .out_quot(cq), .out_tag(ctag)
   );

   // one extra leading zero keeps the two dividers in step
   slpm_div #(.NUM_W(65), .DEN_W(33), .TAG_W(1)) u_thick (
      .clock, .reset, .in_valid(fv), .in_num({1'b0, thick_num}), .in_den(thick_den),
      .in_tag(1'b0), .out_valid(tv), .out_quot(tq), .out_tag(ttag)
   );

   rsp_type st;
   always_comb begin
      st = rsp_type'(ctag);
      rsp_data = st;
      // flag in the side band marks a mixed item
      if (st.new_thickness[0]) begin
         rsp_data.new_below_conc = cq;
      end
      rsp_data.new_thickness = tq;
   end

   assign rsp_valid = cv;

   `SLPM_ASSERT_IMP(a_div_lockstep, clock, reset, cv, tv)
   `SLPM_ASSERT_IMP(a_never_busy, clock, reset, 1'b1, !busy)
   `SLPM_ASSERT_IMP(a_thick_tag, clock, reset, tv, ttag == 1'b0)
   `SLPM_ASSERT_IMP(a_no_pop_no_mass, clock, reset, rsp_valid && !rsp_data.popped, rsp_data.buried_mass_kg == '0)
   `SLPM_ASSERT_NEXT(a_cfg_write, clock, reset, csr_we, sim_mode_ff == $past(csr_wdata))
endmodule
`default_nettype wire
